// ===== rtl/pse_pkg.sv =====
// ----------------------------------------------------------------------------
// pse_pkg
// shared types, constants and the microcode table of the postfix evaluator
// ----------------------------------------------------------------------------
package pse_pkg;

    localparam int DATA_W     = 32;
    localparam int DEPTH      = 64;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int MODE_W     = 2;
    localparam int OPC_W      = 8;
    localparam int STAT_W     = 3;
    localparam int PC_W       = 6;
    localparam int DIV_STEP_W = $clog2(DATA_W);

    localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
    localparam logic [MODE_W-1:0] MODE_OPER = 2'd1;
    localparam logic [MODE_W-1:0] MODE_END  = 2'd2;

    localparam logic [OPC_W-1:0] OP_ADD = 8'd43;
    localparam logic [OPC_W-1:0] OP_SUB = 8'd45;
    localparam logic [OPC_W-1:0] OP_MUL = 8'd42;
    localparam logic [OPC_W-1:0] OP_DIV = 8'd47;
    localparam logic [OPC_W-1:0] OP_REM = 8'd37;

    typedef logic [PC_W-1:0] pc_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_UNDERFLOW = 3'd1,
        ST_BADOP     = 3'd2,
        ST_OVERFLOW  = 3'd3,
        ST_DIVZERO   = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        CND_ALWAYS,
        CND_NEVER,
        CND_NO_TOK,
        CND_MODE_PUSH,
        CND_MODE_OPER,
        CND_MODE_END,
        CND_FULL,
        CND_LT2,
        CND_EMPTY,
        CND_BAD_OP,
        CND_DIV_OP,
        CND_B_ZERO,
        CND_DIV_BUSY,
        CND_OUT_BUSY
    } cond_t;

    typedef enum logic [1:0] {
        SK_NONE,
        SK_PUSH,
        SK_REPL,
        SK_CLR
    } skop_t;

    typedef enum logic [1:0] {
        RS_NONE,
        RS_ALU,
        RS_DIV,
        RS_MEM
    } rsrc_t;

    typedef enum logic {
        RD_TOP1,
        RD_TOP2
    } rsel_t;

    typedef enum logic {
        VS_ZERO,
        VS_R
    } vsel_t;

    typedef struct packed {
        logic    tok_rdy;
        cond_t   cond;
        pc_t     target;
        logic    last;
        rsel_t   rsel;
        logic    ld_b;
        logic    ld_a;
        rsrc_t   rsrc;
        logic    div_start;
        skop_t   skop;
        logic    emit;
        vsel_t   vsel;
        status_t status;
        logic    fin;
    } ctrl_t;

    typedef struct packed {
        logic no_tok;
        logic mode_push;
        logic mode_oper;
        logic mode_end;
        logic full;
        logic lt2;
        logic empty;
        logic bad_op;
        logic div_op;
        logic b_zero;
        logic div_busy;
        logic out_busy;
    } flags_t;

    // program entry points
    localparam pc_t S_FETCH = pc_t'(0);
    localparam pc_t S_IGN   = pc_t'(4);
    localparam pc_t S_PUSH  = pc_t'(6);
    localparam pc_t S_PUSHW = pc_t'(7);
    localparam pc_t S_OPER  = pc_t'(9);
    localparam pc_t S_DIV   = pc_t'(15);
    localparam pc_t S_DIVW  = pc_t'(17);
    localparam pc_t S_STORE = pc_t'(19);
    localparam pc_t S_END   = pc_t'(21);
    localparam pc_t S_ENDW  = pc_t'(24);
    localparam pc_t S_OVF   = pc_t'(26);
    localparam pc_t S_UND   = pc_t'(28);
    localparam pc_t S_BAD   = pc_t'(30);
    localparam pc_t S_DZ    = pc_t'(32);

    function automatic ctrl_t ucode(input pc_t pc);
        ctrl_t w;
        w        = '0;
        w.cond   = CND_NEVER;
        w.target = S_FETCH;
        w.status = ST_OK;
        case (pc)
            // token fetch and dispatch
            pc_t'(0):  begin w.tok_rdy = 1'b1; w.cond = CND_NO_TOK; w.target = S_FETCH; end
            pc_t'(1):  begin w.cond = CND_MODE_PUSH; w.target = S_PUSH; end
            pc_t'(2):  begin w.cond = CND_MODE_OPER; w.target = S_OPER; end
            pc_t'(3):  begin w.cond = CND_MODE_END;  w.target = S_END;  end
            // ignored token
            pc_t'(4):  begin w.cond = CND_OUT_BUSY; w.target = S_IGN; end
            pc_t'(5):  begin w.emit = 1'b1; w.last = 1'b1; end
            // push
            pc_t'(6):  begin w.cond = CND_FULL; w.target = S_OVF; end
            pc_t'(7):  begin w.cond = CND_OUT_BUSY; w.target = S_PUSHW; end
            pc_t'(8):  begin w.skop = SK_PUSH; w.emit = 1'b1; w.last = 1'b1; end
            // operator
            pc_t'(9):  begin w.cond = CND_LT2; w.target = S_UND; end
            pc_t'(10): begin w.rsel = RD_TOP1; end
            pc_t'(11): begin w.ld_b = 1'b1; w.rsel = RD_TOP2; end
            pc_t'(12): begin w.ld_a = 1'b1; w.cond = CND_BAD_OP; w.target = S_BAD; end
            pc_t'(13): begin w.cond = CND_DIV_OP; w.target = S_DIV; end
            pc_t'(14): begin w.rsrc = RS_ALU; w.cond = CND_ALWAYS; w.target = S_STORE; end
            pc_t'(15): begin w.cond = CND_B_ZERO; w.target = S_DZ; end
            pc_t'(16): begin w.div_start = 1'b1; end
            pc_t'(17): begin w.cond = CND_DIV_BUSY; w.target = S_DIVW; end
            pc_t'(18): begin w.rsrc = RS_DIV; end
            pc_t'(19): begin w.cond = CND_OUT_BUSY; w.target = S_STORE; end
            pc_t'(20): begin
                w.skop = SK_REPL; w.emit = 1'b1; w.vsel = VS_R; w.last = 1'b1;
            end
            // end of expression
            pc_t'(21): begin w.cond = CND_EMPTY; w.target = S_UND; end
            pc_t'(22): begin w.rsel = RD_TOP1; end
            pc_t'(23): begin w.rsrc = RS_MEM; end
            pc_t'(24): begin w.cond = CND_OUT_BUSY; w.target = S_ENDW; end
            pc_t'(25): begin
                w.skop = SK_CLR; w.emit = 1'b1; w.vsel = VS_R; w.fin = 1'b1;
                w.last = 1'b1;
            end
            // error exits
            pc_t'(26): begin w.cond = CND_OUT_BUSY; w.target = S_OVF; end
            pc_t'(27): begin
                w.skop = SK_CLR; w.emit = 1'b1; w.status = ST_OVERFLOW; w.fin = 1'b1;
                w.last = 1'b1;
            end
            pc_t'(28): begin w.cond = CND_OUT_BUSY; w.target = S_UND; end
            pc_t'(29): begin
                w.skop = SK_CLR; w.emit = 1'b1; w.status = ST_UNDERFLOW; w.fin = 1'b1;
                w.last = 1'b1;
            end
            pc_t'(30): begin w.cond = CND_OUT_BUSY; w.target = S_BAD; end
            pc_t'(31): begin
                w.skop = SK_CLR; w.emit = 1'b1; w.status = ST_BADOP; w.fin = 1'b1;
                w.last = 1'b1;
            end
            pc_t'(32): begin w.cond = CND_OUT_BUSY; w.target = S_DZ; end
            pc_t'(33): begin
                w.skop = SK_CLR; w.emit = 1'b1; w.status = ST_DIVZERO; w.fin = 1'b1;
                w.last = 1'b1;
            end
            default: begin w.cond = CND_ALWAYS; w.target = S_FETCH; end
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/pse_tok_if.sv =====
// ----------------------------------------------------------------------------
// pse_tok_if
// token request channel: valid/ready with mode, operand and operator code
// ----------------------------------------------------------------------------
interface pse_tok_if import pse_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] operand_value;
    logic [OPC_W-1:0]         op_char;

    modport source (output valid, output mode, output operand_value, output op_char,
                    input ready);
    modport sink   (input valid, input mode, input operand_value, input op_char,
                    output ready);

endinterface

// ===== rtl/pse_res_if.sv =====
// ----------------------------------------------------------------------------
// pse_res_if
// result request channel: valid/ready with value, status and final flag
// ----------------------------------------------------------------------------
interface pse_res_if import pse_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] value;
    logic [STAT_W-1:0]        status;
    logic                     final_res;

    modport source (output valid, output value, output status, output final_res,
                    input ready);
    modport sink   (input valid, input value, input status, input final_res,
                    output ready);

endinterface

// ===== rtl/pse_ram.sv =====
// ----------------------------------------------------------------------------
// pse_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module pse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/pse_div.sv =====
// ----------------------------------------------------------------------------
// pse_div
// iterative signed divider, one quotient bit per cycle, truncating quotient
// ----------------------------------------------------------------------------
module pse_div import pse_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    output logic              busy,
    output logic [DATA_W-1:0] quo,
    output logic [DATA_W-1:0] rem
);

    logic                  busy_reg, busy_next;
    logic [DIV_STEP_W-1:0] step_reg, step_next;
    logic [DATA_W-1:0]     quo_reg, quo_next;
    logic [DATA_W-1:0]     rem_reg, rem_next;
    logic [DATA_W-1:0]     den_reg, den_next;
    logic                  negq_reg, negq_next;
    logic                  negr_reg, negr_next;
    logic [DATA_W:0]       rem_sh;
    logic [DATA_W:0]       diff;

    assign rem_sh = {rem_reg, quo_reg[DATA_W-1]};
    assign diff   = rem_sh - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        negq_next = negq_reg;
        negr_next = negr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = dividend[DATA_W-1] ? (~dividend + DATA_W'(1)) : dividend;
            den_next  = divisor[DATA_W-1] ? (~divisor + DATA_W'(1)) : divisor;
            rem_next  = '0;
            negq_next = dividend[DATA_W-1] ^ divisor[DATA_W-1];
            negr_next = dividend[DATA_W-1];
        end
        else if (busy_reg)
        begin
            // restoring step
            if (!diff[DATA_W])
            begin
                rem_next = diff[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            if (step_reg == DIV_STEP_W'(DATA_W - 1))
            begin
                busy_next = 1'b0;
            end
            else
            begin
                step_next = step_reg + DIV_STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        negq_reg <= negq_next;
        negr_reg <= negr_next;
    end

    assign busy = busy_reg;
    assign quo  = negq_reg ? (~quo_reg + DATA_W'(1)) : quo_reg;
    assign rem  = negr_reg ? (~rem_reg + DATA_W'(1)) : rem_reg;

endmodule

// ===== rtl/pse_seq.sv =====
// ----------------------------------------------------------------------------
// pse_seq
// microcode sequencer: step counter, control table and conditional jumps
// ----------------------------------------------------------------------------
module pse_seq import pse_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  flags_t flags,
    output ctrl_t  ctrl
);

    pc_t   pc_reg, pc_next;
    ctrl_t word;
    logic  taken;

    assign word = ucode(pc_reg);

    always_comb
    begin
        case (word.cond)
            CND_ALWAYS:    taken = 1'b1;
            CND_NEVER:     taken = 1'b0;
            CND_NO_TOK:    taken = flags.no_tok;
            CND_MODE_PUSH: taken = flags.mode_push;
            CND_MODE_OPER: taken = flags.mode_oper;
            CND_MODE_END:  taken = flags.mode_end;
            CND_FULL:      taken = flags.full;
            CND_LT2:       taken = flags.lt2;
            CND_EMPTY:     taken = flags.empty;
            CND_BAD_OP:    taken = flags.bad_op;
            CND_DIV_OP:    taken = flags.div_op;
            CND_B_ZERO:    taken = flags.b_zero;
            CND_DIV_BUSY:  taken = flags.div_busy;
            CND_OUT_BUSY:  taken = flags.out_busy;
            default:       taken = 1'b0;
        endcase
    end

    always_comb
    begin
        if (taken)
        begin
            pc_next = word.target;
        end
        else if (word.last)
        begin
            pc_next = S_FETCH;
        end
        else
        begin
            pc_next = pc_reg + pc_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= S_FETCH;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assign ctrl = word;

endmodule

// ===== rtl/postfix_stack_evaluator.sv =====
// ----------------------------------------------------------------------------
// postfix_stack_evaluator
// postfix expression evaluator on a 64-entry operand stack
// + - * use the alu, / and % the 32-step divider
// one request in flight; the next is fetched once a result is registered
// a finished result waits in the output register; the next result stalls before its emit while it waits
// reset: async active-low, empties the stack and returns the sequencer to fetch
// ----------------------------------------------------------------------------
module postfix_stack_evaluator import pse_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    pse_tok_if.sink   tok,
    pse_res_if.source res
);

    ctrl_t  ctrl;
    flags_t flags;

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              outv_reg, outv_next;
    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [DATA_W-1:0] opv_reg, opv_next;
    logic [OPC_W-1:0]  opc_reg, opc_next;
    logic [DATA_W-1:0] a_reg, a_next;
    logic [DATA_W-1:0] b_reg, b_next;
    logic [DATA_W-1:0] r_reg, r_next;
    logic [DATA_W-1:0] value_reg, value_next;
    status_t           status_reg, status_next;
    logic              fin_reg, fin_next;

    logic [CNT_W-1:0]  cnt_m1, cnt_m2;
    logic              tok_acc;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [DATA_W-1:0] ram_wdata, ram_rdata;
    logic [DATA_W-1:0] alu_res, quo, rem, div_res;
    logic              div_busy;

    pse_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    pse_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pse_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctrl.div_start),
        .dividend (a_reg),
        .divisor  (b_reg),
        .busy     (div_busy),
        .quo      (quo),
        .rem      (rem)
    );

    assign tok.ready = ctrl.tok_rdy;
    assign tok_acc   = tok.valid && ctrl.tok_rdy;

    assign cnt_m1 = cnt_reg - CNT_W'(1);
    assign cnt_m2 = cnt_reg - CNT_W'(2);

    // condition flags for the sequencer
    assign flags.no_tok    = !tok.valid;
    assign flags.mode_push = (mode_reg == MODE_PUSH);
    assign flags.mode_oper = (mode_reg == MODE_OPER);
    assign flags.mode_end  = (mode_reg == MODE_END);
    assign flags.full      = (cnt_reg >= CNT_W'(DEPTH));
    assign flags.lt2       = (cnt_reg < CNT_W'(2));
    assign flags.empty     = (cnt_reg == '0);
    assign flags.bad_op    = !(opc_reg inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_REM});
    assign flags.div_op    = opc_reg inside {OP_DIV, OP_REM};
    assign flags.b_zero    = (b_reg == '0);
    assign flags.div_busy  = div_busy;
    assign flags.out_busy  = outv_reg && !res.ready;

    always_comb
    begin
        case (opc_reg)
            OP_ADD:  alu_res = a_reg + b_reg;
            OP_SUB:  alu_res = a_reg - b_reg;
            OP_MUL:  alu_res = a_reg * b_reg;
            default: alu_res = '0;
        endcase
    end

    assign div_res = (opc_reg == OP_DIV) ? quo : rem;

    // stack memory ports
    assign ram_raddr = (ctrl.rsel == RD_TOP1) ? cnt_m1[ADDR_W-1:0] : cnt_m2[ADDR_W-1:0];
    assign ram_we    = (ctrl.skop == SK_PUSH) || (ctrl.skop == SK_REPL);
    assign ram_waddr = (ctrl.skop == SK_PUSH) ? cnt_reg[ADDR_W-1:0] : cnt_m2[ADDR_W-1:0];
    assign ram_wdata = (ctrl.skop == SK_PUSH) ? opv_reg : r_reg;

    always_comb
    begin
        case (ctrl.skop)
            SK_PUSH: cnt_next = cnt_reg + CNT_W'(1);
            SK_REPL: cnt_next = cnt_m1;
            SK_CLR:  cnt_next = '0;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_comb
    begin
        mode_next = tok_acc ? tok.mode : mode_reg;
        opv_next  = tok_acc ? $unsigned(tok.operand_value) : opv_reg;
        opc_next  = tok_acc ? tok.op_char : opc_reg;
        b_next    = ctrl.ld_b ? ram_rdata : b_reg;
        a_next    = ctrl.ld_a ? ram_rdata : a_reg;
        case (ctrl.rsrc)
            RS_ALU:  r_next = alu_res;
            RS_DIV:  r_next = div_res;
            RS_MEM:  r_next = ram_rdata;
            default: r_next = r_reg;
        endcase
    end

    // output register
    always_comb
    begin
        value_next  = value_reg;
        status_next = status_reg;
        fin_next    = fin_reg;
        if (ctrl.emit)
        begin
            outv_next   = 1'b1;
            value_next  = (ctrl.vsel == VS_R) ? r_reg : '0;
            status_next = ctrl.status;
            fin_next    = ctrl.fin;
        end
        else if (res.ready)
        begin
            outv_next = 1'b0;
        end
        else
        begin
            outv_next = outv_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            outv_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            outv_reg <= outv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        opv_reg    <= opv_next;
        opc_reg    <= opc_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        r_reg      <= r_next;
        value_reg  <= value_next;
        status_reg <= status_next;
        fin_reg    <= fin_next;
    end

    assign res.valid     = outv_reg;
    assign res.value     = $signed(value_reg);
    assign res.status    = status_reg;
    assign res.final_res = fin_reg;

    // checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("stack count beyond depth");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.emit |-> !(outv_reg && !res.ready))
        else $error("result emitted over a pending one");

    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_final_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.emit && ctrl.fin) |=> (cnt_reg == '0))
        else $error("stack not emptied after closing result");

endmodule
